// ===== sv/brb_pkg.sv =====
// Shared types and constants for the byte ring buffer line reader.
package brb_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FREE_W   = 6;
	localparam int unsigned COUNT_W  = 7;

	localparam logic [DATA_W-1:0] NEWLINE = 8'h0A;

	typedef enum logic [OP_W-1:0] {
		OP_PUT        = 2'd0,
		OP_GET        = 2'd1,
		OP_READ_UNTIL = 2'd2,
		OP_READ_LINE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_NO_LINE = 2'd3
	} status_t;

endpackage

// ===== sv/brb_ifs.sv =====
// Request and response channel interfaces of the byte ring buffer line reader.
interface brb_req_if;
	logic                          valid;
	logic                          ready;
	logic [brb_pkg::OP_W-1:0]      opcode;
	logic [brb_pkg::DATA_W-1:0]    data_byte;
	logic [brb_pkg::DATA_W-1:0]    delimiter;

	modport source (output valid, output opcode, output data_byte, output delimiter,
		input ready);
	modport sink (input valid, input opcode, input data_byte, input delimiter,
		output ready);
endinterface

interface brb_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [brb_pkg::DATA_W-1:0]     out_byte;
	logic [brb_pkg::STATUS_W-1:0]   status;
	logic [brb_pkg::FREE_W-1:0]     free_space;
	logic [brb_pkg::COUNT_W-1:0]    read_count;
	logic                           last;

	modport source (output valid, output out_byte, output status, output free_space,
		output read_count, output last, input ready);
	modport sink (input valid, input out_byte, input status, input free_space,
		input read_count, input last, output ready);
endinterface

// ===== sv/brb_mem.sv =====
// Byte storage: one write port, one read port with registered read data.
module brb_mem #(
	parameter int unsigned DEPTH = 32
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(DEPTH)-1:0]           waddr,
	input  logic [brb_pkg::DATA_W-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0]           raddr,
	output logic [brb_pkg::DATA_W-1:0]         rdata
);

	logic [brb_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [brb_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/byte_ring_buffer_line_reader.sv =====
// Top level: byte ring buffer with put, get, read-until and read-line sequencer.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | opcode, data_byte, delimiter
//   rsp     | out | valid / ready | out_byte, status, free_space, read_count, last
//
// One item at a time. Put and rejected or empty operations finish in the accept
// cycle. Each popped byte passes a memory read, then a compare and emit step,
// through the single registered read port and the shared byte comparator; a run
// that drains the buffer before a stop byte closes with an empty result. A line
// read first fetches and checks the stored bytes in turn until it meets a newline.
// Reset clears the indexes, occupancy and sequencer; stored bytes are not cleared.
// A stalled response holds the sequencer wherever it would emit.
module byte_ring_buffer_line_reader #(
	parameter int unsigned DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	brb_req_if.sink     req,
	brb_rsp_if.source   rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_CHECK = 4'b0100,
		S_TAIL  = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		MODE_GET,
		MODE_RUN,
		MODE_SCAN
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;

	logic [AW-1:0] wr_q, wr_d, rd_q, rd_d, scan_ptr_q, scan_ptr_d;
	logic [CW-1:0] occ_q, occ_d, scan_n_q, scan_n_d;
	logic [brb_pkg::COUNT_W-1:0] cnt_q, cnt_d;
	logic [brb_pkg::DATA_W-1:0]  cmp_q, cmp_d;

	logic                         out_valid_q;
	logic [brb_pkg::DATA_W-1:0]   out_byte_q;
	brb_pkg::status_t             out_status_q;
	logic [brb_pkg::FREE_W-1:0]   out_free_q;
	logic [brb_pkg::COUNT_W-1:0]  out_count_q;
	logic                         out_last_q;

	logic                         emit;
	logic [brb_pkg::DATA_W-1:0]   e_byte;
	brb_pkg::status_t             e_status;
	logic [brb_pkg::COUNT_W-1:0]  e_count;
	logic                         e_last;

	logic                         out_room;
	logic                         accept;
	logic                         mem_we;
	logic [AW-1:0]                raddr;
	logic [brb_pkg::DATA_W-1:0]   rdata;
	logic                         hit;
	brb_pkg::op_t                 op;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		next_slot = (i == LAST_SLOT) ? '0 : AW'(i + 1'b1);
	endfunction

	brb_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_q),
		.wdata (req.data_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign out_room  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_room;
	assign accept    = req.valid && req.ready;
	assign op        = brb_pkg::op_t'(req.opcode);
	assign raddr     = (mode_q == MODE_SCAN) ? scan_ptr_q : rd_q;
	// shared comparator: delimiter in a run, newline in a line scan
	assign hit       = (rdata == cmp_q);

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		wr_d       = wr_q;
		rd_d       = rd_q;
		occ_d      = occ_q;
		scan_ptr_d = scan_ptr_q;
		scan_n_d   = scan_n_q;
		cnt_d      = cnt_q;
		cmp_d      = cmp_q;
		mem_we     = 1'b0;
		emit       = 1'b0;
		e_byte     = '0;
		e_status   = brb_pkg::ST_OK;
		e_count    = '0;
		e_last     = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						brb_pkg::OP_PUT: begin
							emit = 1'b1;
							if (occ_q == DEPTH_C) begin
								e_status = brb_pkg::ST_FULL;
							end else begin
								mem_we = 1'b1;
								wr_d   = next_slot(wr_q);
								occ_d  = CW'(occ_q + 1'b1);
							end
						end
						brb_pkg::OP_GET: begin
							mode_d = MODE_GET;
							if (occ_q == '0) begin
								emit     = 1'b1;
								e_status = brb_pkg::ST_EMPTY;
							end else begin
								state_d = S_FETCH;
							end
						end
						brb_pkg::OP_READ_UNTIL: begin
							mode_d = MODE_RUN;
							cmp_d  = req.delimiter;
							cnt_d  = '0;
							if (occ_q == '0) begin
								emit     = 1'b1;
								e_status = brb_pkg::ST_EMPTY;
								e_count  = brb_pkg::COUNT_W'(1);
							end else begin
								state_d = S_FETCH;
							end
						end
						brb_pkg::OP_READ_LINE: begin
							mode_d     = MODE_SCAN;
							cmp_d      = brb_pkg::NEWLINE;
							cnt_d      = '0;
							scan_ptr_d = rd_q;
							scan_n_d   = '0;
							if (occ_q == '0) begin
								emit     = 1'b1;
								e_status = brb_pkg::ST_NO_LINE;
							end else begin
								state_d = S_FETCH;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_FETCH: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (out_room) begin
					case (mode_q)
						MODE_SCAN: begin
							if (hit) begin
								// newline found: rescan from the tail as a run
								mode_d  = MODE_RUN;
								state_d = S_FETCH;
							end else begin
								scan_n_d   = CW'(scan_n_q + 1'b1);
								scan_ptr_d = next_slot(scan_ptr_q);
								if (scan_n_d == occ_q) begin
									emit     = 1'b1;
									e_status = brb_pkg::ST_NO_LINE;
									state_d  = S_IDLE;
								end else begin
									state_d = S_FETCH;
								end
							end
						end
						MODE_GET: begin
							rd_d    = next_slot(rd_q);
							occ_d   = CW'(occ_q - 1'b1);
							emit    = 1'b1;
							e_byte  = rdata;
							state_d = S_IDLE;
						end
						default: begin
							rd_d    = next_slot(rd_q);
							occ_d   = CW'(occ_q - 1'b1);
							cnt_d   = brb_pkg::COUNT_W'(cnt_q + 1'b1);
							emit    = 1'b1;
							e_byte  = rdata;
							e_count = cnt_d;
							if (hit || rdata == '0) begin
								state_d = S_IDLE;
							end else begin
								e_last  = 1'b0;
								state_d = (occ_d == '0) ? S_TAIL : S_FETCH;
							end
						end
					endcase
				end
			end
			S_TAIL: begin
				// drained before a stop byte: close the run with an empty result
				if (out_room) begin
					cnt_d    = brb_pkg::COUNT_W'(cnt_q + 1'b1);
					emit     = 1'b1;
					e_status = brb_pkg::ST_EMPTY;
					e_count  = cnt_d;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_GET;
			wr_q        <= '0;
			rd_q        <= '0;
			occ_q       <= '0;
			scan_ptr_q  <= '0;
			scan_n_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			wr_q       <= wr_d;
			rd_q       <= rd_d;
			occ_q      <= occ_d;
			scan_ptr_q <= scan_ptr_d;
			scan_n_q   <= scan_n_d;
			cnt_q      <= cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_q <= cmp_d;
		if (emit) begin
			out_byte_q   <= e_byte;
			out_status_q <= e_status;
			out_free_q   <= brb_pkg::FREE_W'(DEPTH_C - occ_d);
			out_count_q  <= e_count;
			out_last_q   <= e_last;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_byte   = out_byte_q;
	assign rsp.status     = out_status_q;
	assign rsp.free_space = out_free_q;
	assign rsp.read_count = out_count_q;
	assign rsp.last       = out_last_q;

endmodule
